[hw/rtl/gdad_pkg.sv]
package gdad_pkg;

    localparam int ADD_DAYS_BITS_DEF = 16;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd16383;
    localparam logic [YEAR_W-1:0]  CENTURY   = 14'd100;
    localparam logic [6:0]         LAST_YY   = 7'd99;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PREFIX,
        ST_WALK
    } gdad_state_t;

    typedef struct packed {
        logic load;
        logic inc;
    } gdad_year_cmd_t;

    typedef struct packed {
        logic ready;
        logic leap;
    } gdad_year_stat_t;

    // Length of month m (1..12) in a year whose leap flag is given.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_JAN;
        if (m == MONTH_FEB && leap)
            return FEB_LEAP_LEN;
        else if (m >= MONTH_JAN && m <= MONTH_DEC)
            return MONTH_LEN[idx];
        else
            return MONTH_LEN[0];
    endfunction

endpackage

[hw/rtl/gdad_year_unit.sv]
module gdad_year_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gdad_pkg::gdad_year_cmd_t     cmd,
    input  logic [gdad_pkg::YEAR_W-1:0]  start_year,
    output gdad_pkg::gdad_year_stat_t    stat,
    output logic [gdad_pkg::YEAR_W-1:0]  year
);
    import gdad_pkg::*;

    logic [YEAR_W-1:0] year_reg, year_next;
    // Year modulo 100 once reduction is over; the raw year before that.
    logic [YEAR_W-1:0] yy_reg, yy_next;
    // Count of centuries modulo 4.
    logic [1:0]        cent_reg, cent_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg <= '0;
            yy_reg   <= '0;
            cent_reg <= '0;
        end
        else
        begin
            year_reg <= year_next;
            yy_reg   <= yy_next;
            cent_reg <= cent_next;
        end
    end

    always_comb
    begin
        year_next = year_reg;
        yy_next   = yy_reg;
        cent_next = cent_reg;
        if (cmd.load)
        begin
            year_next = start_year;
            yy_next   = start_year;
            cent_next = '0;
        end
        else if (yy_reg >= CENTURY)
        begin
            yy_next   = yy_reg - CENTURY;
            cent_next = cent_reg + 2'd1;
        end
        else if (cmd.inc && year_reg != YEAR_MAX)
        begin
            year_next = year_reg + 14'd1;
            if (yy_reg[6:0] == LAST_YY)
            begin
                yy_next   = '0;
                cent_next = cent_reg + 2'd1;
            end
            else
            begin
                yy_next = yy_reg + 14'd1;
            end
        end
    end

    always_comb
    begin
        stat.ready = (yy_reg < CENTURY);
        stat.leap  = ((year_reg[1:0] == 2'b00) && (yy_reg != '0))
                   || ((yy_reg == '0) && (cent_reg == 2'b00));
    end

    assign year = year_reg;

endmodule

[hw/rtl/gdad_seq.sv]
module gdad_seq #(
    parameter int ADD_DAYS_BITS = gdad_pkg::ADD_DAYS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gdad_pkg::DAY_W-1:0]    start_day,
    input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
    input  logic [ADD_DAYS_BITS-1:0]      days_to_add,
    input  gdad_pkg::gdad_year_stat_t     year_stat,
    output gdad_pkg::gdad_year_cmd_t      year_cmd,
    output logic                          busy,
    output logic                          done,
    output logic [gdad_pkg::DAY_W-1:0]    end_day,
    output logic [gdad_pkg::MONTH_W-1:0]  end_month
);
    import gdad_pkg::*;

    localparam int REM_W = ADD_DAYS_BITS + 2;

    gdad_state_t        state_reg, state_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [MONTH_W-1:0] m_reg, m_next;
    logic [MONTH_W-1:0] tgt_reg, tgt_next;
    logic               done_reg, done_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] mon_reg, mon_next;

    logic [DAY_W-1:0]   len;
    logic [REM_W-1:0]   len_ext;
    logic               sub;
    logic [REM_W-1:0]   sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        m_reg   <= m_next;
        tgt_reg <= tgt_next;
        day_reg <= day_next;
        mon_reg <= mon_next;
    end

    // The one shared adder: adds month lengths while building the day of
    // the year, and takes them away during the month walk.
    assign len     = month_days(m_reg, year_stat.leap);
    assign len_ext = REM_W'(len);
    assign sum     = rem_reg + (len_ext ^ {REM_W{sub}}) + REM_W'(sub);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        m_next     = m_reg;
        tgt_next   = tgt_reg;
        done_next  = 1'b0;
        day_next   = day_reg;
        mon_next   = mon_reg;
        year_cmd   = '0;
        sub        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next = REM_W'(days_to_add) + REM_W'(start_day);
                    if (start_month < MONTH_JAN)
                        tgt_next = MONTH_JAN;
                    else if (start_month > MONTH_DEC)
                        tgt_next = MONTH_DEC;
                    else
                        tgt_next = start_month;
                    m_next        = MONTH_JAN;
                    year_cmd.load = 1'b1;
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (year_stat.ready)
                    state_next = ST_PREFIX;
            end
            ST_PREFIX:
            begin
                if (m_reg < tgt_reg)
                begin
                    rem_next = sum;
                    m_next   = m_reg + 4'd1;
                end
                else
                begin
                    m_next     = MONTH_JAN;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                sub = 1'b1;
                if (rem_reg > len_ext)
                begin
                    rem_next = sum;
                    if (m_reg == MONTH_DEC)
                    begin
                        m_next       = MONTH_JAN;
                        year_cmd.inc = 1'b1;
                    end
                    else
                    begin
                        m_next = m_reg + 4'd1;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    day_next   = rem_reg[DAY_W-1:0];
                    mon_next   = m_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign end_day   = day_reg;
    assign end_month = mon_reg;

endmodule

[hw/rtl/gregorian_date_add_days_core.sv]
// The year is reduced by centuries, the months before start_month are summed, and then the
// months are walked, where one month is walked per cycle.
// Throughput: one date at a time; busy stays high from acceptance until done pulses.
// The month walk through the single shared add/subtract unit dominates the time to a result.
// done marks the result for one cycle; the receiver cannot stall it.
// Reset (rst_n low, asynchronous) clears busy and done; end_day and end_month are undefined until the first done.
module gregorian_date_add_days_core #(
    parameter int ADD_DAYS_BITS = gdad_pkg::ADD_DAYS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gdad_pkg::DAY_W-1:0]    start_day,
    input  logic [gdad_pkg::MONTH_W-1:0]  start_month,
    input  logic [gdad_pkg::YEAR_W-1:0]   start_year,
    input  logic [ADD_DAYS_BITS-1:0]      days_to_add,
    output logic                          done,
    output logic [gdad_pkg::DAY_W-1:0]    end_day,
    output logic [gdad_pkg::MONTH_W-1:0]  end_month,
    output logic [gdad_pkg::YEAR_W-1:0]   end_year
);
    import gdad_pkg::*;

    gdad_year_cmd_t  year_cmd;
    gdad_year_stat_t year_stat;

    gdad_seq #(
        .ADD_DAYS_BITS(ADD_DAYS_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_day  (start_day),
        .start_month(start_month),
        .days_to_add(days_to_add),
        .year_stat  (year_stat),
        .year_cmd   (year_cmd),
        .busy       (busy),
        .done       (done),
        .end_day    (end_day),
        .end_month  (end_month)
    );

    gdad_year_unit u_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (year_cmd),
        .start_year(start_year),
        .stat      (year_stat),
        .year      (end_year)
    );

    // A result word only appears as the block falls idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("done without a preceding busy period");

    // An accepted word keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // The walk always ends in a real month.
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (end_month >= MONTH_JAN) && (end_month <= MONTH_DEC))
        else $error("result month out of range");

    // The year never moves backwards while a date is being worked on.
    a_year_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy) && !year_cmd.load && !$past(year_cmd.load))
            |-> end_year >= $past(end_year))
        else $error("year went backwards during the walk");

endmodule
